>>> hdl/sm4_pkg.sv
// SM4 shared constants, S-box and linear transforms.
package sm4_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int RND_W       = $clog2(ROUND_COUNT);
  localparam int BLK_W       = 128;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_RUN
  } ks_state_t;

  // entry 0 in the top byte
  localparam logic [2047:0] SBOX_BITS = {
    128'hd690e9fecce13db716b614c228fb2c05,
    128'h2b679a762abe04c3aa44132649860699,
    128'h9c4250f491ef987a33540b43edcfac62,
    128'he4b31ca9c908e89580df94fa758f3fa6,
    128'h4707a7fcf37317ba83593c19e6854fa8,
    128'h686b81b27164da8bf8eb0f4b70569d35,
    128'h1e240e5e6358d1a225227c3b01217887,
    128'hd40046579fd327524c3602e7a0c4c89e,
    128'heabf8ad240c738b5a3f7f2cef96115a1,
    128'he0ae5da49b341a55ad933230f58cb1e3,
    128'h1df6e22e8266ca60c02923ab0d534e6f,
    128'hd5db3745defd8e2f03ff6a726d6c5b51,
    128'h8d1baf92bbddbc7f11d95c411f105ad8,
    128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
    128'h8969974a0c96777e65b9f109c56ec684,
    128'h18f07dec3adc4d2079ee5f3ed7cb3948
  };

  function automatic logic [7:0] sbox(input logic [7:0] v);
    return SBOX_BITS[{~v, 3'b111} -: 8];
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] v);
    return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
  endfunction

  function automatic logic [31:0] lin_data(input logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^
           {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  function automatic logic [31:0] lin_key(input logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // byte j of CK[i] is (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
    logic [31:0] w;
    logic [7:0]  idx;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = 8'({i, 2'(j)});
      w   = {w[23:0], 8'(idx * 8'd7)};
    end
    return w;
  endfunction

endpackage

>>> hdl/sm4_block_cipher.sv
// SM4 ECB block cipher top level: key schedule and 32-stage round pipeline.
//
// Configuration: write cfg_data to register cfg_index with cfg_wr_en high
// (0 key_high, 1 key_low, 2 decrypt_mode in bit 0; index 3 is ignored).
// Each write to a listed register rebuilds the 32 round keys, one per
// cycle, after a load step; in_stall stays high meanwhile. Write only
// while the pipeline is empty.
// Input: a transaction moves one 128-bit block (in_block_high holds bytes
// 0 to 7) at an edge where in_valid is high and in_stall is low.
// Output: the result block passes through the round stage registers in order
// and is offered from the last one; while no key expansion runs and out_stall does
// not hold the pipeline, one block enters and one leaves per cycle, one round per stage.
// The last round stage is the output register. While out_valid is high and
// out_stall is high, the whole pipeline holds and in_stall is high.
// Reset: synchronous, active low; empties the pipeline, clears the key and
// mode to zero and then expands the all-zero key (in_stall high meanwhile).
module sm4_block_cipher
  import sm4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          in_block_high,
  input  logic [63:0]          in_block_low,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_result_high,
  output logic [63:0]          out_result_low
);

  logic                           ks_busy;
  logic [ROUND_COUNT-1:0][31:0]   round_keys;
  logic                           adv;
  logic [ROUND_COUNT:0]           stg_v;
  logic [ROUND_COUNT:0][BLK_W-1:0] stg_x;

  sm4_key_sched u_ks (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (ks_busy),
    .round_keys (round_keys)
  );

  assign adv      = !(out_valid && out_stall);
  assign in_stall = ks_busy || !adv;
  assign stg_v[0] = in_valid && !ks_busy;
  assign stg_x[0] = {in_block_high, in_block_low};

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    sm4_round u_round (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (stg_v[g]),
      .blk_i (stg_x[g]),
      .rk_i  (round_keys[g]),
      .vld_o (stg_v[g+1]),
      .blk_o (stg_x[g+1])
    );
  end

  assign out_valid       = stg_v[ROUND_COUNT];
  assign out_result_high = {stg_x[ROUND_COUNT][31:0], stg_x[ROUND_COUNT][63:32]};
  assign out_result_low  = {stg_x[ROUND_COUNT][95:64], stg_x[ROUND_COUNT][127:96]};

endmodule

>>> hdl/sm4_key_sched.sv
// SM4 key registers and sequential round key expansion.
module sm4_key_sched
  import sm4_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]                 cfg_data,
  output logic                             busy,
  output logic [ROUND_COUNT-1:0][31:0]     round_keys
);

  ks_state_t                  st_r, st_nxt;
  logic [RND_W-1:0]           cnt_r, cnt_nxt;
  logic [63:0]                key_hi_r;
  logic [63:0]                key_lo_r;
  logic                       dec_r;
  logic [3:0][31:0]           k_r;
  logic [ROUND_COUNT-1:0][31:0] rk_r;
  logic                       cfg_hit;
  logic                       last;
  logic [31:0]                rk_new;
  logic [RND_W-1:0]           wr_idx;

  assign cfg_hit = cfg_wr_en && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW ||
                                 cfg_index == CFG_DECRYPT_MODE);
  assign last    = (cnt_r == RND_W'(ROUND_COUNT - 1));
  assign rk_new  = k_r[0] ^ lin_key(subst_word(k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_word(cnt_r)));
  assign wr_idx  = dec_r ? (RND_W'(ROUND_COUNT - 1) - cnt_r) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      dec_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY_HIGH:     key_hi_r <= cfg_data;
        CFG_KEY_LOW:      key_lo_r <= cfg_data;
        CFG_DECRYPT_MODE: dec_r    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= KS_LOAD;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      KS_IDLE: ;
      KS_LOAD: begin
        st_nxt  = KS_RUN;
        cnt_nxt = '0;
      end
      KS_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          st_nxt = KS_IDLE;
        end
      end
      default: st_nxt = KS_IDLE;
    endcase
    if (cfg_hit) begin
      st_nxt = KS_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == KS_LOAD) begin
      k_r[0] <= key_hi_r[63:32] ^ FK0;
      k_r[1] <= key_hi_r[31:0]  ^ FK1;
      k_r[2] <= key_lo_r[63:32] ^ FK2;
      k_r[3] <= key_lo_r[31:0]  ^ FK3;
    end else if (st_r == KS_RUN) begin
      k_r <= {rk_new, k_r[3], k_r[2], k_r[1]};
      rk_r[wr_idx] <= rk_new;
    end
  end

  assign busy       = (st_r != KS_IDLE);
  assign round_keys = rk_r;

endmodule

>>> hdl/sm4_round.sv
// One SM4 round as a registered pipeline stage.
module sm4_round
  import sm4_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             vld_i,
  input  logic [BLK_W-1:0] blk_i,
  input  logic [31:0]      rk_i,
  output logic             vld_o,
  output logic [BLK_W-1:0] blk_o
);

  logic             vld_r;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [31:0]      t;
  logic [31:0]      nx;

  assign t       = blk_i[95:64] ^ blk_i[63:32] ^ blk_i[31:0] ^ rk_i;
  assign nx      = blk_i[127:96] ^ lin_data(subst_word(t));
  assign blk_nxt = {blk_i[95:0], nx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blk_r <= blk_nxt;
    end
  end

  assign vld_o = vld_r;
  assign blk_o = blk_r;

endmodule

>>> hdl/sm4_checker.sv
// Port-level assertions for the SM4 block cipher, bound to the top level.
module sm4_checker
  import sm4_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_wr_en,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [63:0]          out_result_high,
  input logic [63:0]          out_result_low
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_high) &&
                               $stable(out_result_low))
    else $error("stalled output transaction changed");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW ||
                  cfg_index == CFG_DECRYPT_MODE) |=> in_stall)
    else $error("input open during key expansion");

  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not held after reset");

endmodule

bind sm4_block_cipher sm4_checker u_chk (.*);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for sm4_block_cipher: random and directed traffic checked against an SM4 predictor.
module tb_top;

  localparam int ROUNDS       = 32;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 120;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 110;
  localparam int PRINT_LIMIT  = 20;

  localparam logic [sm4_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  localparam logic [31:0] SYS_PARAM0 = 32'ha3b1bac6;
  localparam logic [31:0] SYS_PARAM1 = 32'h56aa3350;
  localparam logic [31:0] SYS_PARAM2 = 32'h677d9197;
  localparam logic [31:0] SYS_PARAM3 = 32'hb27022dc;

  localparam logic [0:15][127:0] SBOX_ROWS = {
    128'hd690e9fecce13db716b614c228fb2c05,
    128'h2b679a762abe04c3aa44132649860699,
    128'h9c4250f491ef987a33540b43edcfac62,
    128'he4b31ca9c908e89580df94fa758f3fa6,
    128'h4707a7fcf37317ba83593c19e6854fa8,
    128'h686b81b27164da8bf8eb0f4b70569d35,
    128'h1e240e5e6358d1a225227c3b01217887,
    128'hd40046579fd327524c3602e7a0c4c89e,
    128'heabf8ad240c738b5a3f7f2cef96115a1,
    128'he0ae5da49b341a55ad933230f58cb1e3,
    128'h1df6e22e8266ca60c02923ab0d534e6f,
    128'hd5db3745defd8e2f03ff6a726d6c5b51,
    128'h8d1baf92bbddbc7f11d95c411f105ad8,
    128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
    128'h8969974a0c96777e65b9f109c56ec684,
    128'h18f07dec3adc4d2079ee5f3ed7cb3948
  };

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_block_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [sm4_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [sm4_pkg::CFG_W-1:0]        cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [63:0]                      in_block_high = '0;
  logic [63:0]                      in_block_low = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [63:0]                      out_result_high;
  logic [63:0]                      out_result_low;

  logic [63:0]   key_hi_q;
  logic [63:0]   key_lo_q;
  logic          decrypt_q;
  logic [31:0]   round_key [ROUNDS];

  cipher_block_t queued_cipher_blocks [$];
  cipher_block_t head_block;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            stall_odds = 0;
  int            gap_odds = 0;
  int            stall_left = 0;
  int            hold_left = 0;
  logic          hold_req = 1'b0;
  logic          hold_seen = 1'b0;

  sm4_block_cipher uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_high (out_result_high),
    .out_result_low  (out_result_low)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] sbox_byte(input logic [7:0] v);
    logic [127:0] row;
    int           col;
    row = SBOX_ROWS[v[7:4]];
    col = int'(v[3:0]);
    return row[127 - 8 * col -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox_byte(w[31:24]), sbox_byte(w[23:16]), sbox_byte(w[15:8]), sbox_byte(w[7:0])};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
    return (w << n) | (w >> (32 - n));
  endfunction

  function automatic logic [31:0] mix_data(input logic [31:0] b);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] mix_key(input logic [31:0] b);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  function automatic logic [31:0] ck_const(input int i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((4 * i + j) * 7)};
    end
    return w;
  endfunction

  function automatic void rebuild_round_keys();
    logic [31:0] k [4];
    logic [31:0] rk;
    k[0] = key_hi_q[63:32] ^ SYS_PARAM0;
    k[1] = key_hi_q[31:0] ^ SYS_PARAM1;
    k[2] = key_lo_q[63:32] ^ SYS_PARAM2;
    k[3] = key_lo_q[31:0] ^ SYS_PARAM3;
    for (int i = 0; i < ROUNDS; i++) begin
      rk = k[0] ^ mix_key(sub_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i)));
      if (decrypt_q) begin
        round_key[ROUNDS - 1 - i] = rk;
      end else begin
        round_key[i] = rk;
      end
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = rk;
    end
  endfunction

  function automatic cipher_block_t sm4_transform(input logic [63:0] hi, input logic [63:0] lo);
    logic [31:0]   x [4];
    logic [31:0]   nx;
    cipher_block_t res;
    x[0] = hi[63:32];
    x[1] = hi[31:0];
    x[2] = lo[63:32];
    x[3] = lo[31:0];
    for (int r = 0; r < ROUNDS; r++) begin
      nx = x[0] ^ mix_data(sub_word(x[1] ^ x[2] ^ x[3] ^ round_key[r]));
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    res.hi = {x[3], x[2]};
    res.lo = {x[1], x[0]};
    return res;
  endfunction

  function automatic void apply_reg(input logic [sm4_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [63:0] data);
    case (idx)
      sm4_pkg::CFG_KEY_HIGH: key_hi_q = data;
      sm4_pkg::CFG_KEY_LOW: key_lo_q = data;
      sm4_pkg::CFG_DECRYPT_MODE: decrypt_q = data[0];
      default: return;
    endcase
    rebuild_round_keys();
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got %h expected %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // hold the payload until the transaction completes; valid stays up for the next one
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    in_valid <= 1'b1;
    in_block_high <= hi;
    in_block_low <= lo;
    do @(posedge clk); while (in_stall !== 1'b0);
    queued_cipher_blocks.push_back(sm4_transform(hi, lo));
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (queued_cipher_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // drain, write, then wait out the key expansion
  task automatic write_reg(input logic [sm4_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    settle_pipeline();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_wr_en <= 1'b0;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic test_zero_key();
    stall_odds = 6;
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_block(64'ha5a5_a5a5_5a5a_5a5a, 64'h0f0f_f0f0_3c3c_c3c3);
    send_block(rand64(), rand64());
  endtask

  task automatic test_standard_vector();
    write_reg(sm4_pkg::CFG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
    write_reg(sm4_pkg::CFG_KEY_LOW, 64'hfedc_ba98_7654_3210);
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_block(rand64(), rand64());
    write_reg(sm4_pkg::CFG_DECRYPT_MODE, 64'd1);
    send_block(64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246);
    send_block(rand64(), rand64());
  endtask

  task automatic test_register_corners();
    write_reg(sm4_pkg::CFG_KEY_HIGH, '1);
    write_reg(sm4_pkg::CFG_KEY_LOW, '1);
    send_block('1, '0);
    // stray high bits in the mode register
    write_reg(sm4_pkg::CFG_DECRYPT_MODE, 64'hffff_ffff_ffff_fffe);
    send_block('0, '1);
    write_reg(sm4_pkg::CFG_DECRYPT_MODE, 64'h8000_0000_0000_0001);
    send_block(rand64(), rand64());
    // unlisted index must leave the schedule alone
    write_reg(CFG_NO_REG, '1);
    send_block(rand64(), rand64());
    // partial key update
    write_reg(sm4_pkg::CFG_KEY_LOW, '0);
    send_block(rand64(), rand64());
    write_reg(sm4_pkg::CFG_KEY_HIGH, '0);
    send_block(rand64(), rand64());
  endtask

  task automatic test_pipeline_backpressure();
    write_reg(sm4_pkg::CFG_KEY_HIGH, rand64());
    stall_odds = 0;
    hold_req <= ~hold_req;
    for (int i = 0; i < 64; i++) begin
      send_block(rand64(), rand64());
    end
  endtask

  task automatic test_random_traffic();
    logic quiet;
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == PHASES - 1);
      case ($urandom_range(0, 4))
        0: begin
          write_reg(sm4_pkg::CFG_KEY_HIGH, rand64());
          write_reg(sm4_pkg::CFG_KEY_LOW, rand64());
          write_reg(sm4_pkg::CFG_DECRYPT_MODE, rand64());
        end
        1: write_reg(sm4_pkg::CFG_KEY_HIGH, rand64());
        2: write_reg(sm4_pkg::CFG_DECRYPT_MODE, rand64());
        3: begin
          write_reg(sm4_pkg::CFG_KEY_LOW, $urandom_range(0, 1) ? '1 : '0);
          write_reg(CFG_NO_REG, rand64());
        end
        default: write_reg(sm4_pkg::CFG_KEY_LOW, rand64());
      endcase
      stall_odds = quiet ? 0 : (p % 3 == 0 ? 0 : $urandom_range(3, 8));
      gap_odds = quiet ? 0 : (p % 3 == 1 ? 0 : $urandom_range(3, 8));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          idle_input($urandom_range(1, 4));
        end
        case ($urandom_range(0, 15))
          0: send_block('0, rand64());
          1: send_block(rand64(), '1);
          default: send_block(rand64(), rand64());
        endcase
      end
    end
  endtask

  initial begin
    key_hi_q = '0;
    key_lo_q = '0;
    decrypt_q = 1'b0;
    rebuild_round_keys();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_key();
    test_standard_vector();
    test_register_corners();
    test_pipeline_backpressure();
    test_random_traffic();
    settle_pipeline();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && queued_cipher_blocks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (queued_cipher_blocks.size() == 0) begin
        flag_mismatch("result with none pending", out_result_high, '0);
      end else begin
        head_block = queued_cipher_blocks.pop_front();
        if (out_result_high !== head_block.hi) begin
          flag_mismatch("result_high", out_result_high, head_block.hi);
        end
        if (out_result_low !== head_block.lo) begin
          flag_mismatch("result_low", out_result_low, head_block.lo);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

>>> filelist.f
hdl/sm4_pkg.sv
hdl/sm4_key_sched.sv
hdl/sm4_round.sv
hdl/sm4_block_cipher.sv
hdl/sm4_checker.sv
verif/tb_top.sv
